/* rtl/sfs_pkg.sv */
// shared types and constants for the slot allocator with free stack
`default_nettype none

package sfs_pkg;

    // number of slots the bitmap and the free stack can hold
    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);
    // counts run from zero up to DEPTH inclusive
    localparam int CNT_W = 11;
    localparam int SLOT_W = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CHECK = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_DUP     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_INDEX = 1'b0,
        CFG_CAPACITY   = 1'b1
    } t_cfg_reg;

    // request transaction
    typedef struct packed {
        logic [1:0]        kind;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] granted_index;
        logic              is_allocated;
        logic [CNT_W-1:0]  used_slots;
        logic [CNT_W-1:0]  free_slots;
    } t_out_item;

    // one bitmap write
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic             bit_val;
    } t_bm_wr;

    // one free stack operation
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [IDX_W-1:0] data;
    } t_stk_op;

endpackage

`default_nettype wire

/* rtl/sfs_bitmap.sv */
// allocated bitmap memory with read port and last-write forwarding
`default_nettype none

module sfs_bitmap (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clear,
    input  wire logic                  i_rd_en,
    input  wire logic [sfs_pkg::IDX_W-1:0] i_rd_addr,
    input  wire logic [sfs_pkg::IDX_W-1:0] i_chk_addr,
    input  wire sfs_pkg::t_bm_wr       i_wr,
    output logic                       o_bit
);
    import sfs_pkg::*;

    logic             r_mem [DEPTH];
    logic             r_rd;
    logic             r_fw_vld;
    logic [IDX_W-1:0] r_fw_addr;
    logic             r_fw_bit;

    // memory write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.bit_val;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // remember the latest write; it may have missed the pending read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_fw_vld <= 1'b0;
        end else if (i_wr.en) begin
            r_fw_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_fw_addr <= i_wr.addr;
            r_fw_bit  <= i_wr.bit_val;
        end
    end

    // forwarded bit for the request being decided
    assign o_bit = (r_fw_vld && r_fw_addr == i_chk_addr) ? r_fw_bit : r_rd;

endmodule

`default_nettype wire

/* rtl/sfs_stack.sv */
// lifo free stack: top of stack register backed by a memory with prefetch
`default_nettype none

module sfs_stack (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clear,
    input  wire sfs_pkg::t_stk_op      i_op,
    output logic [sfs_pkg::IDX_W-1:0]  o_top,
    output logic [sfs_pkg::CNT_W-1:0]  o_depth
);
    import sfs_pkg::*;

    logic [IDX_W-1:0] r_mem [DEPTH];
    logic [IDX_W-1:0] r_rd;
    logic [IDX_W-1:0] r_top;
    logic [CNT_W-1:0] r_depth;
    logic [CNT_W-1:0] n_depth;
    logic [CNT_W-1:0] rd_ptr;

    // depth after this cycle's operation
    always_comb begin
        n_depth = r_depth;
        if (i_op.push) begin
            n_depth = r_depth + CNT_W'(1);
        end else if (i_op.pop) begin
            n_depth = r_depth - CNT_W'(1);
        end
    end

    // prefetch the entry just below the next top
    assign rd_ptr = n_depth - CNT_W'(2);

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_mem[r_depth[IDX_W-1:0]] <= i_op.data;
        end
        r_rd <= r_mem[rd_ptr[IDX_W-1:0]];
    end

    // top of stack follows pushes and pops
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_top <= i_op.data;
        end else if (i_op.pop) begin
            r_top <= r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    assign o_top   = r_top;
    assign o_depth = r_depth;

endmodule

`default_nettype wire

/* rtl/slot_allocator_free_stack_top.sv */
// Slot allocator over a window of global indices with a lifo free list.
// Each request (allocate, free, check) is registered on acceptance, decided
// from the request register and placed in the result register when that
// register is empty or the output does not stall, so one request per cycle
// is taken while the output does not stall. The rate is set by the
// top-of-stack register, whose next entry is prefetched from the stack
// memory every cycle, and by the single bitmap read port with forwarding
// of the latest write. The bitmap needs no clearing pass: entries at or
// above the bump counter read as free. Configuration writes reset the
// counters and the stack.
`default_nettype none

module slot_allocator_free_stack_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire sfs_pkg::t_in_item            i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output sfs_pkg::t_out_item                o_out_data,
    input  wire logic                         i_cfg_we,
    input  wire logic [sfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfs_pkg::*;

    // configuration
    logic [SLOT_W-1:0] r_base;
    logic [CNT_W-1:0]  r_cap;
    logic              cfg_clear;

    // request register
    logic              r_req_vld;
    t_in_item          r_req;
    logic [SLOT_W-1:0] r_req_off;

    // allocator counters
    logic [CNT_W-1:0]  r_bump;
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  n_bump;
    logic [CNT_W-1:0]  n_used;

    // result register
    logic              r_out_vld;
    t_out_item         r_out;
    t_out_item         n_out;

    logic              in_accept;
    logic              advance;
    logic              fire;
    logic [SLOT_W-1:0] in_off;
    logic [IDX_W-1:0]  req_local;
    logic              owned;
    logic              map_raw;
    logic              map_bit;
    logic [IDX_W-1:0]  stk_top;
    logic [CNT_W-1:0]  stk_depth;
    logic [IDX_W-1:0]  grant_local;
    t_bm_wr            bm_wr;
    t_stk_op           stk_op;

    // handshake
    assign advance    = !r_out_vld || !i_out_stall;
    assign fire       = r_req_vld && advance;
    assign o_in_stall = r_req_vld && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cfg_clear  = i_cfg_we;

    // configuration registers, capacity taken from the low CNT_W data bits and saturated at DEPTH
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_cap  <= CNT_W'(DEPTH);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_INDEX: r_base <= i_cfg_data;
                CFG_CAPACITY: begin
                    if (i_cfg_data[CNT_W-1:0] > CNT_W'(DEPTH)) begin
                        r_cap <= CNT_W'(DEPTH);
                    end else begin
                        r_cap <= i_cfg_data[CNT_W-1:0];
                    end
                end
                default: r_base <= r_base;
            endcase
        end
    end

    // local offset of the incoming slot
    assign in_off = i_in_data.slot_index - r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (in_accept) begin
            r_req_vld <= 1'b1;
        end else if (fire) begin
            r_req_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req     <= i_in_data;
            r_req_off <= in_off;
        end
    end

    assign req_local = r_req_off[IDX_W-1:0];
    assign owned     = (r_req.slot_index != '1) && (r_req_off < SLOT_W'(r_cap));
    // entries at or above the bump counter were never marked since clear
    assign map_bit   = map_raw && ({1'b0, req_local} < r_bump);

    sfs_bitmap u_bitmap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_clear),
        .i_rd_en    (in_accept),
        .i_rd_addr  (in_off[IDX_W-1:0]),
        .i_chk_addr (req_local),
        .i_wr       (bm_wr),
        .o_bit      (map_raw)
    );

    sfs_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_clear),
        .i_op    (stk_op),
        .o_top   (stk_top),
        .o_depth (stk_depth)
    );

    // request decision
    always_comb begin
        n_bump      = r_bump;
        n_used      = r_used;
        grant_local = '0;
        bm_wr       = '0;
        stk_op      = '0;
        n_out       = '0;
        n_out.status = ST_INVALID;

        case (r_req.kind)
            KIND_ALLOC: begin
                if (stk_depth != '0) begin
                    stk_op.pop  = fire;
                    grant_local = stk_top;
                    if ({1'b0, stk_top} < r_cap) begin
                        n_out.status = ST_OK;
                    end else begin
                        n_out.status = ST_EMPTY;
                    end
                end else if (r_bump < r_cap) begin
                    grant_local  = r_bump[IDX_W-1:0];
                    n_bump       = r_bump + CNT_W'(1);
                    n_out.status = ST_OK;
                end else begin
                    n_out.status = ST_EMPTY;
                end
                if (n_out.status == ST_OK) begin
                    bm_wr.en            = fire;
                    bm_wr.addr          = grant_local;
                    bm_wr.bit_val       = 1'b1;
                    n_used              = r_used + CNT_W'(1);
                    n_out.granted_index = r_base + SLOT_W'(grant_local);
                end
            end
            KIND_FREE: begin
                if (owned) begin
                    if (!map_bit) begin
                        n_out.status = ST_DUP;
                    end else begin
                        n_out.status  = ST_OK;
                        bm_wr.en      = fire;
                        bm_wr.addr    = req_local;
                        bm_wr.bit_val = 1'b0;
                        if (r_used != '0) begin
                            n_used = r_used - CNT_W'(1);
                        end
                        stk_op.push = fire && (stk_depth < CNT_W'(DEPTH));
                        stk_op.data = req_local;
                    end
                end
            end
            KIND_CHECK: begin
                if (owned) begin
                    n_out.status       = ST_OK;
                    n_out.is_allocated = map_bit;
                end
            end
            default: n_out.status = ST_INVALID;
        endcase

        n_out.used_slots = n_used;
        n_out.free_slots = (r_cap >= n_used) ? r_cap - n_used : '0;
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_clear) begin
            r_bump <= '0;
            r_used <= '0;
        end else if (fire) begin
            r_bump <= n_bump;
            r_used <= n_used;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
